>>> sv/framed_link_receiver_with_value_table_macros.svh
// ----------------------------------------------------------------------------
// framed link receiver assertion macros
// shared concurrent assertion shorthands, clocked on clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef FRAMED_LINK_RECEIVER_WITH_VALUE_TABLE_MACROS_SVH
`define FRAMED_LINK_RECEIVER_WITH_VALUE_TABLE_MACROS_SVH

// same-cycle implication
`define FRLR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRLR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/frlr_pkg.sv
// ----------------------------------------------------------------------------
// frlr_pkg
// constants and types shared by the framed link receiver and its interfaces
// ----------------------------------------------------------------------------
package frlr_pkg;

  // sizes
  localparam int FRAME_DEPTH     = 32;
  localparam int ID_COUNT        = 256;
  localparam int DIR_COUNT       = 4;
  localparam int EVENT_FRAME_LEN = 7;
  localparam int MIN_STATUS_LEN  = 14;

  localparam int TBL_DEPTH = ID_COUNT * DIR_COUNT;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int ID_W      = $clog2(ID_COUNT);
  localparam int DIR_W     = $clog2(DIR_COUNT);

  // field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int SEQ_W   = 4;
  localparam int TYPE_W  = 3;
  localparam int CNT_W   = 16;
  localparam int IDS_W   = 11;
  localparam int TIME_W  = 32;
  localparam int VAL_W   = 16;
  localparam int AGE_W   = 23;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // ms to s: age / 1000 == (age * MAGIC) >> 38 for every 32-bit age
  localparam int              MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
  localparam int              DIV_SHIFT = 38;
  localparam int              PROD_W    = TIME_W + MAGIC_W;

  // register reset values
  localparam logic [BYTE_W-1:0] STATUS_START_RST = 8'hF0;
  localparam logic [BYTE_W-1:0] EVENT_START_RST  = 8'hF2;
  localparam logic [LEN_W-1:0]  STATUS_LEN_RST   = 6'd24;
  localparam logic [TIME_W-1:0] STALE_LIMIT_RST  = 32'd120000;

  // byte positions inside a frame
  localparam logic [LEN_W-1:0] POS_DIR    = 6'd1;
  localparam logic [LEN_W-1:0] POS_TYPE   = 6'd2;
  localparam logic [LEN_W-1:0] POS_ID     = 6'd3;
  localparam logic [LEN_W-1:0] POS_VAL_HI = 6'd4;
  localparam logic [LEN_W-1:0] POS_VAL_LO = 6'd5;
  localparam logic [LEN_W-1:0] POS_SEQ    = 6'd12;

  // message types that are kept for replies
  localparam logic [TYPE_W-1:0] MSG_READ_ACK  = 3'd4;
  localparam logic [TYPE_W-1:0] MSG_WRITE_ACK = 3'd5;

  // direction codes
  localparam logic [BYTE_W-1:0] DIR_FROM_BOILER = 8'd1;
  localparam logic [BYTE_W-1:0] DIR_TO_STAT     = 8'd3;
  localparam logic [BYTE_W-1:0] DIR_MAX         = 8'd3;

  typedef enum logic {
    OP_RX_BYTE = 1'b0,
    OP_QUERY   = 1'b1
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_STATUS_START = 2'd0,
    CFG_EVENT_START  = 2'd1,
    CFG_STATUS_LEN   = 2'd2,
    CFG_STALE_LIMIT  = 2'd3
  } cfg_idx_t;

  // one value table entry
  typedef struct packed {
    logic              written;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] stamp;
  } tbl_entry_t;

  // one result transaction
  typedef struct packed {
    logic              frame_done;
    logic              frame_kind;
    logic              sum_error;
    logic              event_stored;
    logic [CNT_W-1:0]  bad_sum_count;
    logic [CNT_W-1:0]  missed_count;
    logic [IDS_W-1:0]  ids_seen;
    logic              have_status;
    logic              query_written;
    logic              query_fresh;
    logic [VAL_W-1:0]  query_value;
    logic [AGE_W-1:0]  query_age_s;
  } result_t;

endpackage

>>> sv/frlr_in_if.sv
// ----------------------------------------------------------------------------
// frlr_in_if
// input channel: received link bytes and table queries
// ----------------------------------------------------------------------------
interface frlr_in_if;
  import frlr_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;
  logic [ID_W-1:0]   query_id;
  logic [DIR_W-1:0]  query_dir;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, op, rx_byte, query_id, query_dir, now_ms, input ready);
  modport sink   (input valid, op, rx_byte, query_id, query_dir, now_ms, output ready);
endinterface

>>> sv/frlr_out_if.sv
// ----------------------------------------------------------------------------
// frlr_out_if
// result channel: frame status, counters and query answers
// ----------------------------------------------------------------------------
interface frlr_out_if;
  import frlr_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_done;
  logic              frame_kind;
  logic              sum_error;
  logic              event_stored;
  logic [CNT_W-1:0]  bad_sum_count;
  logic [CNT_W-1:0]  missed_count;
  logic [IDS_W-1:0]  ids_seen;
  logic              have_status;
  logic              query_written;
  logic              query_fresh;
  logic [VAL_W-1:0]  query_value;
  logic [AGE_W-1:0]  query_age_s;

  modport source (output valid, frame_done, frame_kind, sum_error, event_stored,
                  bad_sum_count, missed_count, ids_seen, have_status, query_written,
                  query_fresh, query_value, query_age_s, input ready);
  modport sink   (input valid, frame_done, frame_kind, sum_error, event_stored,
                  bad_sum_count, missed_count, ids_seen, have_status, query_written,
                  query_fresh, query_value, query_age_s, output ready);
endinterface

>>> sv/framed_link_receiver_with_value_table.sv
// ----------------------------------------------------------------------------
// framed_link_receiver_with_value_table
// frames received link bytes, checks sums, keeps a value table per direction
// and ID and answers queries on value, freshness and age
// ----------------------------------------------------------------------------
// One transaction (a received byte or a query) is accepted per clock while
// in_ch.ready is high; its result passes the table, age and multiply stages
// into an 8-deep result queue, and ready drops once the queue and those
// stages hold eight results. The value table is a 1024 x 49 memory with a
// registered read: a frame-ending event byte reads its entry in the cycle
// after acceptance and writes it back in that same cycle, and the following
// transaction gets the written entry by forwarding. Age in seconds comes from
// a registered 32 x 29 reciprocal multiply. After reset the block clears every
// table entry, with in_ch.ready low; configuration writes are taken meanwhile.
`include "framed_link_receiver_with_value_table_macros.svh"

module framed_link_receiver_with_value_table (
  input  logic                        clk,
  input  logic                        rst_n,
  frlr_in_if.sink                     in_ch,
  frlr_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [frlr_pkg::CFG_AW-1:0] cfg_idx,
  input  logic [frlr_pkg::CFG_DW-1:0] cfg_wdata
);
  import frlr_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] status_start_r;
  logic [BYTE_W-1:0] event_start_r;
  logic [LEN_W-1:0]  status_len_r;
  logic [TIME_W-1:0] stale_limit_r;

  // frame state
  logic [LEN_W-1:0]  byte_idx_r, byte_idx_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [BYTE_W-1:0] run_sum_r, run_sum_nxt;
  logic [BYTE_W-1:0] ev_dir_r, ev_dir_nxt;
  logic [TYPE_W-1:0] ev_type_r, ev_type_nxt;
  logic [ID_W-1:0]   ev_id_r, ev_id_nxt;
  logic [VAL_W-1:0]  ev_val_r, ev_val_nxt;
  logic [SEQ_W-1:0]  st_seq_r, st_seq_nxt;

  // counters and status flags
  logic [CNT_W-1:0]  bad_frames_r, bad_frames_nxt;
  logic [CNT_W-1:0]  missed_r, missed_nxt;
  logic [SEQ_W-1:0]  last_seq_r, last_seq_nxt;
  logic              seq_known_r, seq_known_nxt;
  logic              status_seen_r, status_seen_nxt;
  logic [IDS_W-1:0]  distinct_r, distinct_nxt;

  // accept stage
  logic              in_acc;
  logic              take;
  logic [BYTE_W-1:0] sum_base;
  logic [LEN_W-1:0]  exp_cur;
  logic [LEN_W-1:0]  idx_inc;
  logic [LEN_W-1:0]  len_eff;
  logic [SEQ_W-1:0]  gap;
  logic              s0_done, s0_kind, s0_serr, s0_store;
  logic [TBL_AW-1:0] s0_slot;

  // table stage
  logic              s1_valid_r;
  logic              s1_op_r;
  logic              s1_done_r, s1_kind_r, s1_serr_r, s1_store_r;
  logic [TBL_AW-1:0] s1_slot_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [VAL_W-1:0]  s1_val_r;
  logic [CNT_W-1:0]  s1_bad_r, s1_missed_r;
  logic              s1_have_r;
  tbl_entry_t        s1_ent;
  logic              s1_wr;
  logic              s1_qw;
  logic [TIME_W-1:0] s1_age;
  result_t           s1_res;

  // age and multiply stages
  logic              s2_valid_r;
  result_t           s2_res_r;
  logic [TIME_W-1:0] s2_age_r;
  logic              s3_valid_r;
  result_t           s3_res_r;
  logic [PROD_W-1:0] s3_prod_r;

  // value table
  tbl_entry_t        tbl_mem [TBL_DEPTH];
  tbl_entry_t        tbl_rdata_r;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  tbl_entry_t        tbl_wdata;
  logic              fwd_valid_r;
  logic [TBL_AW-1:0] fwd_slot_r;
  tbl_entry_t        fwd_data_r;
  logic              clr_busy_r;
  logic [TBL_AW-1:0] clr_idx_r;

  // result queue
  result_t           fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] fifo_wp_r, fifo_rp_r;
  logic [FIFO_CW-1:0] fifo_cnt_r;
  logic [FIFO_CW-1:0] occ;
  logic              fifo_push, fifo_pop;
  result_t           fifo_head;
  result_t           push_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_start_r <= STATUS_START_RST;
      event_start_r  <= EVENT_START_RST;
      status_len_r   <= STATUS_LEN_RST;
      stale_limit_r  <= STALE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_STATUS_START: status_start_r <= cfg_wdata[BYTE_W-1:0];
        CFG_EVENT_START:  event_start_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_STATUS_LEN:   status_len_r   <= cfg_wdata[LEN_W-1:0];
        CFG_STALE_LIMIT:  stale_limit_r  <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // status frame length clamped to the legal range
  always_comb begin
    if (status_len_r < LEN_W'(MIN_STATUS_LEN)) begin
      len_eff = LEN_W'(MIN_STATUS_LEN);
    end else if (status_len_r > LEN_W'(FRAME_DEPTH)) begin
      len_eff = LEN_W'(FRAME_DEPTH);
    end else begin
      len_eff = status_len_r;
    end
  end

  // credit check against the result queue
  assign occ = fifo_cnt_r + FIFO_CW'(s1_valid_r) + FIFO_CW'(s2_valid_r)
             + FIFO_CW'(s3_valid_r);
  assign in_ch.ready = !clr_busy_r && (occ < FIFO_CW'(FIFO_DEPTH));
  assign in_acc      = in_ch.valid && in_ch.ready;

  // framing, sum check, status sequence and event decision
  always_comb begin
    byte_idx_nxt    = byte_idx_r;
    exp_len_nxt     = exp_len_r;
    run_sum_nxt     = run_sum_r;
    ev_dir_nxt      = ev_dir_r;
    ev_type_nxt     = ev_type_r;
    ev_id_nxt       = ev_id_r;
    ev_val_nxt      = ev_val_r;
    st_seq_nxt      = st_seq_r;
    bad_frames_nxt  = bad_frames_r;
    missed_nxt      = missed_r;
    last_seq_nxt    = last_seq_r;
    seq_known_nxt   = seq_known_r;
    status_seen_nxt = status_seen_r;
    take            = 1'b0;
    sum_base        = run_sum_r;
    exp_cur         = exp_len_r;
    idx_inc         = byte_idx_r + LEN_W'(1);
    gap             = st_seq_r - last_seq_r;
    s0_done         = 1'b0;
    s0_kind         = 1'b0;
    s0_serr         = 1'b0;
    s0_store        = 1'b0;
    s0_slot         = {in_ch.query_dir, in_ch.query_id};

    if (in_acc && (op_t'(in_ch.op) == OP_RX_BYTE)) begin
      take = 1'b1;
      // start byte opens a frame, status wins a tie
      if (byte_idx_r == '0) begin
        sum_base = '0;
        if (in_ch.rx_byte == status_start_r) begin
          exp_cur = len_eff;
        end else if (in_ch.rx_byte == event_start_r) begin
          exp_cur = LEN_W'(EVENT_FRAME_LEN);
        end else begin
          take = 1'b0;
        end
      end

      if (take) begin
        // pick out the bytes that are decoded later
        case (byte_idx_r)
          POS_DIR:    ev_dir_nxt = in_ch.rx_byte;
          POS_TYPE:   ev_type_nxt = in_ch.rx_byte[6:4];
          POS_ID:     ev_id_nxt = in_ch.rx_byte;
          POS_VAL_HI: ev_val_nxt[VAL_W-1:BYTE_W] = in_ch.rx_byte;
          POS_VAL_LO: ev_val_nxt[BYTE_W-1:0] = in_ch.rx_byte;
          POS_SEQ:    st_seq_nxt = in_ch.rx_byte[7:4];
          default: ;
        endcase

        exp_len_nxt = exp_cur;
        if (idx_inc < exp_cur) begin
          byte_idx_nxt = idx_inc;
          run_sum_nxt  = sum_base + in_ch.rx_byte;
        end else begin
          // last byte carries the sum
          s0_done      = 1'b1;
          s0_kind      = (exp_cur == LEN_W'(EVENT_FRAME_LEN));
          byte_idx_nxt = '0;
          run_sum_nxt  = '0;
          if (sum_base != in_ch.rx_byte) begin
            s0_serr        = 1'b1;
            bad_frames_nxt = bad_frames_r + CNT_W'(1);
          end else if (s0_kind) begin
            s0_slot  = {ev_dir_r[DIR_W-1:0], ev_id_r};
            s0_store = (ev_dir_r <= DIR_MAX) &&
                       !(((ev_dir_r == DIR_FROM_BOILER) || (ev_dir_r == DIR_TO_STAT)) &&
                         (ev_type_r != MSG_READ_ACK) && (ev_type_r != MSG_WRITE_ACK));
          end else begin
            if (seq_known_r && (gap > SEQ_W'(1))) begin
              missed_nxt = missed_r + CNT_W'(gap) - CNT_W'(1);
            end
            last_seq_nxt    = st_seq_r;
            seq_known_nxt   = 1'b1;
            status_seen_nxt = 1'b1;
          end
        end
      end
    end
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r    <= '0;
      exp_len_r     <= '0;
      run_sum_r     <= '0;
      bad_frames_r  <= '0;
      missed_r      <= '0;
      last_seq_r    <= '0;
      seq_known_r   <= 1'b0;
      status_seen_r <= 1'b0;
    end else begin
      byte_idx_r    <= byte_idx_nxt;
      exp_len_r     <= exp_len_nxt;
      run_sum_r     <= run_sum_nxt;
      bad_frames_r  <= bad_frames_nxt;
      missed_r      <= missed_nxt;
      last_seq_r    <= last_seq_nxt;
      seq_known_r   <= seq_known_nxt;
      status_seen_r <= status_seen_nxt;
    end
  end

  // captured frame bytes
  always_ff @(posedge clk) begin
    ev_dir_r  <= ev_dir_nxt;
    ev_type_r <= ev_type_nxt;
    ev_id_r   <= ev_id_nxt;
    ev_val_r  <= ev_val_nxt;
    st_seq_r  <= st_seq_nxt;
  end

  // table stage payload
  always_ff @(posedge clk) begin
    s1_op_r     <= in_ch.op;
    s1_done_r   <= s0_done;
    s1_kind_r   <= s0_kind;
    s1_serr_r   <= s0_serr;
    s1_store_r  <= s0_store;
    s1_slot_r   <= s0_slot;
    s1_now_r    <= in_ch.now_ms;
    s1_val_r    <= ev_val_r;
    s1_bad_r    <= bad_frames_nxt;
    s1_missed_r <= missed_nxt;
    s1_have_r   <= status_seen_nxt;
  end

  // value table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_r <= tbl_mem[s0_slot];
  end

  // entry as seen by the table stage, with the previous write forwarded
  assign s1_ent = (fwd_valid_r && (fwd_slot_r == s1_slot_r)) ? fwd_data_r : tbl_rdata_r;
  assign s1_wr  = s1_valid_r && s1_store_r;

  // write mux: clearing pass or event store
  always_comb begin
    if (clr_busy_r) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx_r;
      tbl_wdata = '0;
    end else begin
      tbl_we            = s1_wr;
      tbl_waddr         = s1_slot_r;
      tbl_wdata.written = 1'b1;
      tbl_wdata.value   = s1_val_r;
      tbl_wdata.stamp   = s1_now_r;
    end
  end

  // distinct count and query answer
  always_comb begin
    distinct_nxt = distinct_r;
    if (s1_wr && !s1_ent.written) begin
      distinct_nxt = distinct_r + IDS_W'(1);
    end
    s1_qw  = s1_valid_r && (op_t'(s1_op_r) == OP_QUERY) && s1_ent.written;
    s1_age = s1_qw ? (s1_now_r - s1_ent.stamp) : '0;

    s1_res.frame_done    = s1_done_r;
    s1_res.frame_kind    = s1_kind_r;
    s1_res.sum_error     = s1_serr_r;
    s1_res.event_stored  = s1_store_r;
    s1_res.bad_sum_count = s1_bad_r;
    s1_res.missed_count  = s1_missed_r;
    s1_res.ids_seen      = distinct_nxt;
    s1_res.have_status   = s1_have_r;
    s1_res.query_written = s1_qw;
    s1_res.query_fresh   = s1_qw && (s1_age <= stale_limit_r);
    s1_res.query_value   = s1_qw ? s1_ent.value : '0;
    s1_res.query_age_s   = '0;
  end

  // clearing pass, forwarding and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      fwd_valid_r <= 1'b0;
      distinct_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + TBL_AW'(1);
        if (clr_idx_r == TBL_AW'(TBL_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      fwd_valid_r <= s1_wr;
      distinct_r  <= distinct_nxt;
      s1_valid_r  <= in_acc;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
    end
  end

  // forwarded write data
  always_ff @(posedge clk) begin
    fwd_slot_r <= s1_slot_r;
    fwd_data_r <= tbl_wdata;
  end

  // age register, then reciprocal multiply
  always_ff @(posedge clk) begin
    s2_res_r  <= s1_res;
    s2_age_r  <= s1_age;
    s3_res_r  <= s2_res_r;
    s3_prod_r <= PROD_W'(s2_age_r) * PROD_W'(DIV_MAGIC);
  end

  // seconds from the product
  always_comb begin
    push_res             = s3_res_r;
    push_res.query_age_s = s3_prod_r[PROD_W-1:DIV_SHIFT];
  end

  // result queue
  assign fifo_push = s3_valid_r;
  assign fifo_pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[fifo_wp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wp_r <= fifo_wp_r + FIFO_AW'(1);
      end
      if (fifo_pop) begin
        fifo_rp_r <= fifo_rp_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(fifo_push) - FIFO_CW'(fifo_pop);
    end
  end

  // output transaction
  assign fifo_head            = fifo_mem[fifo_rp_r];
  assign out_ch.valid         = (fifo_cnt_r != '0);
  assign out_ch.frame_done    = fifo_head.frame_done;
  assign out_ch.frame_kind    = fifo_head.frame_kind;
  assign out_ch.sum_error     = fifo_head.sum_error;
  assign out_ch.event_stored  = fifo_head.event_stored;
  assign out_ch.bad_sum_count = fifo_head.bad_sum_count;
  assign out_ch.missed_count  = fifo_head.missed_count;
  assign out_ch.ids_seen      = fifo_head.ids_seen;
  assign out_ch.have_status   = fifo_head.have_status;
  assign out_ch.query_written = fifo_head.query_written;
  assign out_ch.query_fresh   = fifo_head.query_fresh;
  assign out_ch.query_value   = fifo_head.query_value;
  assign out_ch.query_age_s   = fifo_head.query_age_s;

  // checks
  `FRLR_ASSERT_IMP(a_no_accept_while_clearing, in_acc, !clr_busy_r, "transaction accepted during clearing pass")
  `FRLR_ASSERT_IMP(a_fifo_no_overflow, fifo_push, (fifo_cnt_r < FIFO_CW'(FIFO_DEPTH)) || fifo_pop, "result queue overflow")
  `FRLR_ASSERT_NXT(a_frame_end_rewinds, in_acc && s0_done, byte_idx_r == '0, "byte index not cleared after frame end")
  `FRLR_ASSERT_IMP(a_bad_count_on_sum_error, bad_frames_r != $past(bad_frames_r), $past(in_acc && s0_serr), "bad frame count moved without a sum error")

endmodule
